>>> hw/rtl/rtsa_pkg.sv
package rtsa_pkg;

  // Volume limits; the size and layer registers saturate to these.
  localparam int MAX_SIZE   = 512;
  localparam int MAX_LAYERS = 256;

  // Field widths of the channels and registers.
  localparam int COORD_W    = 9;
  localparam int LAYER_W    = 8;
  localparam int IDX_W      = 26;
  localparam int SIZE_CFG_W = 10;
  localparam int LYR_CFG_W  = 9;
  localparam int SHIFT_W    = 11;
  localparam int TRIG_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Q1.14 scaling of cosine and sine.
  localparam int QF = 14;

  // Saturation values, clipped to what the registers can hold.
  localparam int SAT_SIZE = (MAX_SIZE > (2**SIZE_CFG_W - 1)) ? (2**SIZE_CFG_W - 1) : MAX_SIZE;
  localparam int SAT_LYR  = (MAX_LAYERS > (2**LYR_CFG_W - 1)) ? (2**LYR_CFG_W - 1) : MAX_LAYERS;

  // Datapath widths.
  localparam int S_W   = SIZE_CFG_W;                        // saturated size
  localparam int L_W   = LYR_CFG_W;                         // saturated layer count
  localparam int X_W   = ((S_W > COORD_W) ? S_W : COORD_W) + 1; // centered coordinate
  localparam int P_W   = X_W + TRIG_W;                      // one rotation product
  localparam int OFF_W = ((S_W > SHIFT_W) ? S_W : SHIFT_W) + 1;
  localparam int NUM_W = P_W + 3;                           // rotated sum before rounding
  localparam int Q_W   = NUM_W - QF + 1;                    // rounded coordinate
  localparam int A_W   = 2 * S_W + 1;                       // row-level partial index
  localparam int B_W   = (S_W > L_W) ? S_W : L_W;           // second stride
  localparam int IP_W  = A_W + B_W + 1;                     // full index before truncation

  // Rounding bias, rounded coordinates are biased then shifted down.
  localparam logic [NUM_W:0] BIAS_POS = (NUM_W+1)'(2**(QF-1));
  localparam logic [NUM_W:0] BIAS_NEG = (NUM_W+1)'(2**(QF-1) - 1);

  // Register map of the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LAYERS = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTX = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SHIFTY = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_COS    = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_SIN    = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR  = CFG_IDX_W'(7);

  // Memory layouts.
  localparam logic LAYOUT_INTERLEAVED = 1'b0;
  localparam logic LAYOUT_SLICED      = 1'b1;

endpackage

>>> hw/rtl/rtsa_if.sv
interface rtsa_in_if;
  import rtsa_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_i;
  logic [COORD_W-1:0] coord_j;
  logic [LAYER_W-1:0] layer;
  modport source (output valid, output coord_i, output coord_j, output layer, input ready);
  modport sink   (input valid, input coord_i, input coord_j, input layer, output ready);
endinterface

interface rtsa_out_if;
  import rtsa_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] source_index;
  logic             outside;
  modport source (output valid, output source_index, output outside, input ready);
  modport sink   (input valid, input source_index, input outside, output ready);
endinterface

interface rtsa_cfg_if;
  import rtsa_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/rotate_translate_source_address.sv
// Nearest-neighbor rotation/translation source address generator. Each transfer on in_ch
// carries a destination voxel (coord_i, coord_j, layer); the block rotates the in-plane point
// about the slice center with the Q1.14 cosine and sine registers, subtracts shift_x/shift_y,
// rounds half away from zero (or floors when floor_mode is set) and returns the linear source
// buffer index in the selected layout, or outside=1 with index 0 when the point or layer falls
// outside the volume. Throughput is one item per clock while out_ch takes results; each
// input transfer passes through the six-stage datapath (center, four rotation products,
// sums, rounding, range check with first index multiply-add, second index multiply-add),
// whose first stage loads at the input transfer edge. Every stage advances on its own, so
// bubbles are squeezed out and in_ch keeps taking items while a finished result waits on
// out_ch until every stage is full. cfg_ch is always ready; write registers only while no
// item is in flight. The reset state is size 512, 256 layers, no shift, identity rotation,
// interleaved layout and round-half-away mode.
module rotate_translate_source_address (
  input  logic      clk,
  input  logic      rst_n,
  rtsa_in_if.sink   in_ch,
  rtsa_out_if.source out_ch,
  rtsa_cfg_if.sink  cfg_ch
);
  import rtsa_pkg::*;

  localparam int NSTG = 6;

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [SIZE_CFG_W-1:0]     size_r;
  logic [LYR_CFG_W-1:0]      layers_r;
  logic signed [SHIFT_W-1:0] shift_x_r;
  logic signed [SHIFT_W-1:0] shift_y_r;
  logic signed [TRIG_W-1:0]  cos_r;
  logic signed [TRIG_W-1:0]  sin_r;
  logic                      layout_r;
  logic                      floor_r;

  assign cfg_ch.ready = 1'b1;

  // Decode the register index; drop writes beyond the map.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= SIZE_CFG_W'(512);
      layers_r  <= LYR_CFG_W'(256);
      shift_x_r <= '0;
      shift_y_r <= '0;
      cos_r     <= TRIG_W'(16384);
      sin_r     <= '0;
      layout_r  <= LAYOUT_INTERLEAVED;
      floor_r   <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_SIZE:   size_r    <= cfg_ch.data[SIZE_CFG_W-1:0];
        REG_LAYERS: layers_r  <= cfg_ch.data[LYR_CFG_W-1:0];
        REG_SHIFTX: shift_x_r <= cfg_ch.data[SHIFT_W-1:0];
        REG_SHIFTY: shift_y_r <= cfg_ch.data[SHIFT_W-1:0];
        REG_COS:    cos_r     <= cfg_ch.data[TRIG_W-1:0];
        REG_SIN:    sin_r     <= cfg_ch.data[TRIG_W-1:0];
        REG_LAYOUT: layout_r  <= cfg_ch.data[0];
        REG_FLOOR:  floor_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Saturated size and layer count, slice center.
  logic [S_W-1:0]   s_sat;
  logic [L_W-1:0]   l_sat;
  logic [S_W-2:0]   center;

  assign s_sat  = (size_r > S_W'(SAT_SIZE)) ? S_W'(SAT_SIZE) : size_r;
  assign l_sat  = (layers_r > L_W'(SAT_LYR)) ? L_W'(SAT_LYR) : layers_r;
  assign center = s_sat[S_W-1:1];

  // ---------------------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its content moves on.
  // ---------------------------------------------------------------------------------------
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !v_r[NSTG-1] || out_ch.ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
    v_nxt[0] = adv[0] ? in_ch.valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      v_nxt[i] = adv[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready = adv[0];

  // ---------------------------------------------------------------------------------------
  // Stage 1: move the point to the slice center.
  // ---------------------------------------------------------------------------------------
  logic signed [X_W-1:0] x_r, y_r;
  logic [LAYER_W-1:0]    k1_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_r  <= $signed(X_W'(in_ch.coord_i)) - $signed(X_W'(center));
      y_r  <= $signed(X_W'(in_ch.coord_j)) - $signed(X_W'(center));
      k1_r <= in_ch.layer;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 2: the four rotation products.
  // ---------------------------------------------------------------------------------------
  logic signed [P_W-1:0] xc_r, ys_r, xs_r, yc_r;
  logic [LAYER_W-1:0]    k2_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      xc_r <= P_W'(x_r) * P_W'(cos_r);
      ys_r <= P_W'(y_r) * P_W'(sin_r);
      xs_r <= P_W'(x_r) * P_W'(sin_r);
      yc_r <= P_W'(y_r) * P_W'(cos_r);
      k2_r <= k1_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 3: combine products and add the scaled center minus shift.
  // ---------------------------------------------------------------------------------------
  logic signed [OFF_W-1:0] off_i, off_j;
  logic signed [NUM_W-1:0] num_i_r, num_j_r;
  logic [LAYER_W-1:0]      k3_r;

  assign off_i = $signed(OFF_W'(center)) - OFF_W'(shift_x_r);
  assign off_j = $signed(OFF_W'(center)) - OFF_W'(shift_y_r);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      num_i_r <= NUM_W'(xc_r) - NUM_W'(ys_r) + (NUM_W'(off_i) <<< QF);
      num_j_r <= NUM_W'(xs_r) + NUM_W'(yc_r) + (NUM_W'(off_j) <<< QF);
      k3_r    <= k2_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 4: round back to whole pixels.
  // ---------------------------------------------------------------------------------------
  logic signed [Q_W-1:0] qi, qj;
  logic signed [Q_W-1:0] ni_r, nj_r;
  logic [LAYER_W-1:0]    k4_r;

  rtsa_quant u_quant_i (.num(num_i_r), .floor_mode(floor_r), .q(qi));
  rtsa_quant u_quant_j (.num(num_j_r), .floor_mode(floor_r), .q(qj));

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ni_r <= qi;
      nj_r <= qj;
      k4_r <= k3_r;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 5: range check, first multiply-add of the index.
  //   interleaved: (nj*S + ni)*L + k     sliced: (k*S + nj)*S + ni
  // ---------------------------------------------------------------------------------------
  logic           in_vol;
  logic [S_W-1:0] a1, c1;
  logic [A_W-1:0] part_r;
  logic [S_W-1:0] c2_r;
  logic           outside5_r;

  always_comb begin
    in_vol = !ni_r[Q_W-1] && (ni_r < $signed(Q_W'(s_sat)))
          && !nj_r[Q_W-1] && (nj_r < $signed(Q_W'(s_sat)))
          && ((L_W + 1)'(k4_r) < (L_W + 1)'(l_sat));
    if (layout_r == LAYOUT_SLICED) begin
      a1 = S_W'(k4_r);
      c1 = nj_r[S_W-1:0];
    end else begin
      a1 = nj_r[S_W-1:0];
      c1 = ni_r[S_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      part_r     <= A_W'(a1) * A_W'(s_sat) + A_W'(c1);
      c2_r       <= (layout_r == LAYOUT_SLICED) ? ni_r[S_W-1:0] : S_W'(k4_r);
      outside5_r <= !in_vol;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stage 6: second multiply-add, output register.
  // ---------------------------------------------------------------------------------------
  logic [B_W-1:0]  b2;
  logic [IP_W-1:0] full_idx;
  logic [IDX_W-1:0] idx_r;
  logic             outside_r;

  assign b2       = (layout_r == LAYOUT_SLICED) ? B_W'(s_sat) : B_W'(l_sat);
  assign full_idx = IP_W'(part_r) * IP_W'(b2) + IP_W'(c2_r);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      idx_r     <= outside5_r ? '0 : IDX_W'(full_idx);
      outside_r <= outside5_r;
    end
  end

  assign out_ch.valid        = v_r[NSTG-1];
  assign out_ch.source_index = idx_r;
  assign out_ch.outside      = outside_r;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  logic in_xfer, out_xfer;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  // Items in the pipeline change only by transfers on either side.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ($countones(v_r) ==
      $countones($past(v_r)) + int'($past(in_xfer)) - int'($past(out_xfer))))
    else $error("pipeline occupancy does not match transfers");

  // A full pipeline with a stalled output takes no new item.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&v_r) && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while pipeline full and stalled");

  // A new result on the output came out of the first multiply-add stage.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_ch.valid) |-> $past(v_r[NSTG-2]))
    else $error("result appeared without an item in the stage before");

endmodule

>>> hw/rtl/rtsa_quant.sv
module rtsa_quant (
  input  logic signed [rtsa_pkg::NUM_W-1:0] num,
  input  logic                              floor_mode,
  output logic signed [rtsa_pkg::Q_W-1:0]   q
);
  import rtsa_pkg::*;

  logic [NUM_W:0]        bias;
  logic signed [NUM_W:0] biased;

  // Floor takes no bias; half away from zero biases negatives one short of a half.
  always_comb begin
    if (floor_mode) begin
      bias = '0;
    end else if (num[NUM_W-1]) begin
      bias = BIAS_NEG;
    end else begin
      bias = BIAS_POS;
    end
    biased = $signed((NUM_W+1)'(num)) + $signed(bias);
  end

  assign q = biased[NUM_W:QF];

endmodule

>>> tb/rotate_translate_source_address_tb.sv
module rotate_translate_source_address_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rtsa_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Settle time after the last result; the datapath is six stages deep.
  localparam int SETTLE_CYCLES  = 12;
  // Long receiver hold-off that backs the pipeline up into the input.
  localparam int HOLD_CYCLES    = 80;
  localparam longint Q_UNIT     = longint'(1) << QF;

  // Index values past the register map; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_FLOOR + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = '1;

  typedef struct {
    logic [COORD_W-1:0] coord_i;
    logic [COORD_W-1:0] coord_j;
    logic [LAYER_W-1:0] layer;
  } voxel_t;

  typedef struct {
    logic [IDX_W-1:0] source_index;
    logic             outside;
  } src_addr_t;

  logic clk;
  logic rst_n;

  rtsa_in_if  in_ch ();
  rtsa_out_if out_ch ();
  rtsa_cfg_if cfg_ch ();

  rotate_translate_source_address uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Local copy of the register file, updated on every accepted config transfer.
  bit        [SIZE_CFG_W-1:0] size_reg;
  bit        [LYR_CFG_W-1:0]  layers_reg;
  bit signed [SHIFT_W-1:0]    shift_x_reg;
  bit signed [SHIFT_W-1:0]    shift_y_reg;
  bit signed [TRIG_W-1:0]     cos_reg;
  bit signed [TRIG_W-1:0]     sin_reg;
  bit                         layout_reg;
  bit                         floor_reg;

  voxel_t    pending_voxels[$];
  src_addr_t expected_addrs[$];

  int sender_gap_pct;
  int receiver_stall_pct;
  int errors;
  int results_seen;
  int hold_left;
  int idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Divide by 2^14: round half away from zero, or floor.
  function automatic longint quantize_q14(longint num);
    if (num >= 0)
      return floor_reg ? (num >>> QF) : ((num + (Q_UNIT / 2)) >>> QF);
    return floor_reg ? -((-num + Q_UNIT - 1) >>> QF) : -((-num + (Q_UNIT / 2)) >>> QF);
  endfunction

  function automatic src_addr_t predict_source_address(voxel_t v);
    longint s, l, c, x, y, cs, sn, sx, sy, ni, nj, k, idx;
    src_addr_t r;
    s  = (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
    l  = (layers_reg > MAX_LAYERS) ? MAX_LAYERS : layers_reg;
    c  = s / 2;
    x  = longint'(v.coord_i) - c;
    y  = longint'(v.coord_j) - c;
    k  = longint'(v.layer);
    cs = cos_reg;
    sn = sin_reg;
    sx = shift_x_reg;
    sy = shift_y_reg;
    ni = quantize_q14(x * cs - y * sn + (c - sx) * Q_UNIT);
    nj = quantize_q14(x * sn + y * cs + (c - sy) * Q_UNIT);
    if (ni < 0 || ni >= s || nj < 0 || nj >= s || k >= l) begin
      r.source_index = '0;
      r.outside      = 1'b1;
      return r;
    end
    if (layout_reg == LAYOUT_INTERLEAVED)
      idx = nj * s * l + ni * l + k;
    else
      idx = k * s * s + nj * s + ni;
    r.source_index = idx[IDX_W-1:0];
    r.outside      = 1'b0;
    return r;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SIZE:   size_reg    = val[SIZE_CFG_W-1:0];
      REG_LAYERS: layers_reg  = val[LYR_CFG_W-1:0];
      REG_SHIFTX: shift_x_reg = val[SHIFT_W-1:0];
      REG_SHIFTY: shift_y_reg = val[SHIFT_W-1:0];
      REG_COS:    cos_reg     = val[TRIG_W-1:0];
      REG_SIN:    sin_reg     = val[TRIG_W-1:0];
      REG_LAYOUT: layout_reg  = val[0];
      REG_FLOOR:  floor_reg   = val[0];
      default: ;
    endcase
  endfunction

  // Input driver: advance to the next pending voxel once the current one
  // has been transferred; predict each voxel at the edge it is accepted.
  always @(posedge clk) begin : drive_voxels
    voxel_t v;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        v.coord_i = in_ch.coord_i;
        v.coord_j = in_ch.coord_j;
        v.layer   = in_ch.layer;
        expected_addrs.push_back(predict_source_address(v));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_voxels.size() != 0 && $urandom_range(99) >= sender_gap_pct) begin
          v = pending_voxels.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.coord_i <= v.coord_i;
          in_ch.coord_j <= v.coord_j;
          in_ch.layer   <= v.layer;
        end else begin
          // idle cycle: drop valid and scramble the payload
          in_ch.valid   <= 1'b0;
          in_ch.coord_i <= COORD_W'($urandom_range(511));
          in_ch.coord_j <= COORD_W'($urandom_range(511));
          in_ch.layer   <= LAYER_W'($urandom_range(255));
        end
      end
    end
  end

  // Result monitor: compare each transfer against the oldest prediction
  // and throttle ready, with an occasional long hold-off.
  always @(posedge clk) begin : check_addresses
    src_addr_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      results_seen = 0;
      hold_left    = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_addrs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, actual source_index %0d outside %0b",
                   $time, out_ch.source_index, out_ch.outside);
        end else begin
          want = expected_addrs.pop_front();
          if (out_ch.source_index !== want.source_index) begin
            errors++;
            $display("%0t: source_index mismatch, expected %0d, actual %0d",
                     $time, want.source_index, out_ch.source_index);
          end
          if (out_ch.outside !== want.outside) begin
            errors++;
            $display("%0t: outside mismatch, expected %0b, actual %0b",
                     $time, want.outside, out_ch.outside);
          end
        end
        if (results_seen % 190 == 60)
          hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still outstanding",
               $time, expected_addrs.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold until every queued voxel is transferred and every result is back,
  // then let the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_voxels.size() != 0 || in_ch.valid || expected_addrs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_register(idx, val);
  endtask

  task automatic write_setting(int size, int layers, int sx, int sy, int cs, int sn,
                               logic layout, logic flr);
    cfg_write(REG_SIZE,   CFG_DATA_W'(size));
    cfg_write(REG_LAYERS, CFG_DATA_W'(layers));
    cfg_write(REG_SHIFTX, CFG_DATA_W'(sx));
    cfg_write(REG_SHIFTY, CFG_DATA_W'(sy));
    cfg_write(REG_COS,    CFG_DATA_W'(cs));
    cfg_write(REG_SIN,    CFG_DATA_W'(sn));
    cfg_write(REG_LAYOUT, CFG_DATA_W'(layout));
    cfg_write(REG_FLOOR,  CFG_DATA_W'(flr));
    @(negedge clk);
  endtask

  task automatic queue_voxel(int i, int j, int k);
    voxel_t v;
    v.coord_i = COORD_W'(i);
    v.coord_j = COORD_W'(j);
    v.layer   = LAYER_W'(k);
    pending_voxels.push_back(v);
  endtask

  // Pick a random setting: mostly a real rotation with a modest shift over a
  // legal even size, now and then raw register contents.
  task automatic random_setting();
    int  size, layers, sx, sy, cs, sn;
    real ang;
    size   = ($urandom_range(9) == 0) ? $urandom_range(1023) : 2 * $urandom_range(1, 256);
    layers = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 256);
    if ($urandom_range(4) == 0) begin
      sx = $urandom_range(16'hFFFF);
      sy = $urandom_range(16'hFFFF);
    end else begin
      sx = $urandom_range(size / 2) - size / 4;
      sy = $urandom_range(size / 2) - size / 4;
    end
    if ($urandom_range(5) == 0) begin
      cs = $urandom_range(16'hFFFF);
      sn = $urandom_range(16'hFFFF);
    end else begin
      ang = $urandom_range(359) * 3.14159265358979 / 180.0;
      cs  = int'($cos(ang) * 16384.0);
      sn  = int'($sin(ang) * 16384.0);
    end
    write_setting(size, layers, sx, sy, cs, sn, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // Mostly voxels inside the configured volume, the rest anywhere in the field.
  task automatic random_phase(int n, int gap, int stall);
    int s_eff, l_eff;
    random_setting();
    sender_gap_pct     = gap;
    receiver_stall_pct = stall;
    s_eff = (size_reg > MAX_SIZE) ? MAX_SIZE : size_reg;
    l_eff = (layers_reg > MAX_LAYERS) ? MAX_LAYERS : layers_reg;
    repeat (n) begin
      if (s_eff > 0 && l_eff > 0 && $urandom_range(4) != 0)
        queue_voxel($urandom_range(s_eff - 1), $urandom_range(s_eff - 1),
                    $urandom_range(l_eff - 1));
      else
        queue_voxel($urandom_range(511), $urandom_range(511), $urandom_range(255));
    end
    wait_drained();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.coord_i      = '0;
    in_ch.coord_j      = '0;
    in_ch.layer        = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    errors             = 0;
    idle_cycles        = 0;
    sender_gap_pct     = 25;
    receiver_stall_pct = 70;
    // reset contents of the register file
    size_reg    = 10'd512;
    layers_reg  = 9'd256;
    shift_x_reg = '0;
    shift_y_reg = '0;
    cos_reg     = 16'sd16384;
    sin_reg     = '0;
    layout_reg  = LAYOUT_INTERLEAVED;
    floor_reg   = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset setting, identity: field extremes and alternating bit patterns,
    // including the largest index the field can hold.
    queue_voxel(0, 0, 0);
    queue_voxel(511, 511, 255);
    queue_voxel(511, 0, 255);
    queue_voxel(170, 341, 85);
    queue_voxel(341, 170, 170);
    wait_drained();

    // Odd size, floor mode, exact half-pixel products, sliced layout,
    // layer past the configured count.
    write_setting(7, 3, -3, 2, 8192, -8192, LAYOUT_SLICED, 1'b1);
    queue_voxel(0, 0, 0);
    queue_voxel(3, 3, 2);
    queue_voxel(6, 6, 3);
    queue_voxel(2, 5, 1);
    queue_voxel(1, 4, 0);
    queue_voxel(511, 511, 255);
    wait_drained();

    // Size and layer count above the maximum saturate; halves round away
    // from zero; writes past the register map change nothing.
    write_setting(1023, 511, -1, 1, 8192, 8192, LAYOUT_INTERLEAVED, 1'b0);
    cfg_write(REG_UNUSED_FIRST, '1);
    cfg_write(REG_UNUSED_LAST, '1);
    @(negedge clk);
    queue_voxel(1, 4, 0);
    queue_voxel(300, 41, 255);
    queue_voxel(0, 511, 7);
    queue_voxel(511, 0, 200);
    wait_drained();

    // Zero size, then zero layers: everything lands outside. Trig registers
    // at their extremes, shifts at -512 and 512.
    write_setting(0, 256, -512, 512, -32768, 32767, LAYOUT_SLICED, 1'b1);
    queue_voxel(0, 0, 0);
    queue_voxel(5, 5, 5);
    wait_drained();
    cfg_write(REG_SIZE, CFG_DATA_W'(512));
    cfg_write(REG_LAYERS, '0);
    @(negedge clk);
    queue_voxel(1, 1, 0);
    wait_drained();

    // Random settings under each idling pattern.
    repeat (3) random_phase(50, 25, 70);
    repeat (3) random_phase(50, 70, 25);
    repeat (3) random_phase(50, 0, 0);

    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> rotate_translate_source_address.f
hw/rtl/rtsa_pkg.sv
hw/rtl/rtsa_if.sv
hw/rtl/rtsa_quant.sv
hw/rtl/rotate_translate_source_address.sv
tb/rotate_translate_source_address_tb.sv
